### sv/utf8d_pkg.sv
package utf8d_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;

  localparam int CP_BITS  = 31;
  localparam int LEN_BITS = 3;
  localparam int OUT_BITS = 32;

  // Leading-ones masks of a byte; a lead of length n from 2 to 6 matches TOP(n) under TOP(n+1).
  localparam logic [7:0] TOP1 = 8'h80;
  localparam logic [7:0] TOP2 = 8'hC0;
  localparam logic [7:0] TOP3 = 8'hE0;
  localparam logic [7:0] TOP4 = 8'hF0;
  localparam logic [7:0] TOP5 = 8'hF8;
  localparam logic [7:0] TOP6 = 8'hFC;
  localparam logic [7:0] TOP7 = 8'hFE;
  localparam logic [7:0] LOW6 = 8'h3F;

  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [CP_BITS-1:0]  code_point;
    logic [LEN_BITS-1:0] seq_length;
    status_t             status;
    logic [OUT_BITS-1:0] char_ordinal;
    logic [OUT_BITS-1:0] byte_offset;
  } result_t;

endpackage

### sv/utf8d_core.sv
module utf8d_core #(
  parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        text_byte,
  output logic              res_valid,
  output utf8d_pkg::result_t res
);
  import utf8d_pkg::*;

  logic [CP_BITS-1:0]    partial_value, partial_value_next;
  logic [LEN_BITS-1:0]   bytes_remaining, bytes_remaining_next;
  logic [LEN_BITS-1:0]   sequence_length, sequence_length_next;
  logic [COUNT_BITS-1:0] char_count, char_count_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic                  halted, halted_next;

  logic                lead_ok;
  logic [CP_BITS-1:0]  lead_pv;
  logic [LEN_BITS-1:0] lead_len;
  logic                do_finish, do_stop;
  status_t             stop_status;
  logic [CP_BITS-1:0]  fin_pv;
  logic [LEN_BITS-1:0] fin_len;

  always_comb begin
    lead_ok  = 1'b1;
    lead_pv  = '0;
    lead_len = 3'd1;
    priority if ((text_byte & TOP1) == 8'h00) begin
      lead_pv  = CP_BITS'(text_byte);
      lead_len = 3'd1;
    end else if ((text_byte & TOP2) == TOP1) begin
      lead_ok = 1'b0;
    end else if ((text_byte & TOP3) == TOP2) begin
      lead_pv  = CP_BITS'(text_byte & ~TOP3);
      lead_len = 3'd2;
    end else if ((text_byte & TOP4) == TOP3) begin
      lead_pv  = CP_BITS'(text_byte & ~TOP4);
      lead_len = 3'd3;
    end else if ((text_byte & TOP5) == TOP4) begin
      lead_pv  = CP_BITS'(text_byte & ~TOP5);
      lead_len = 3'd4;
    end else if ((text_byte & TOP6) == TOP5) begin
      lead_pv  = CP_BITS'(text_byte & ~TOP6);
      lead_len = 3'd5;
    end else if ((text_byte & TOP7) == TOP6) begin
      lead_pv  = CP_BITS'(text_byte & ~TOP7);
      lead_len = 3'd6;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    char_count_next      = char_count;
    byte_count_next      = byte_count;
    halted_next          = halted;
    do_finish            = 1'b0;
    do_stop              = 1'b0;
    stop_status          = ST_INVALID;
    fin_pv               = partial_value;
    fin_len              = sequence_length;
    res_valid            = 1'b0;
    res.code_point       = '0;
    res.seq_length       = '0;
    res.status           = ST_CHAR;
    res.char_ordinal     = OUT_BITS'(char_count);
    res.byte_offset      = OUT_BITS'(byte_count);

    if (step && !halted) begin
      if (bytes_remaining != '0) begin
        if ((text_byte & TOP2) != TOP1) begin
          do_stop = 1'b1;
        end else begin
          fin_pv               = {partial_value[CP_BITS-7:0], text_byte[5:0]};
          partial_value_next   = fin_pv;
          bytes_remaining_next = bytes_remaining - 3'd1;
          do_finish            = (bytes_remaining == 3'd1);
        end
      end else if (text_byte == 8'h00) begin
        do_stop     = 1'b1;
        stop_status = ST_END;
      end else if (!lead_ok) begin
        do_stop = 1'b1;
      end else begin
        fin_pv               = lead_pv;
        fin_len              = lead_len;
        partial_value_next   = lead_pv;
        sequence_length_next = lead_len;
        bytes_remaining_next = lead_len - 3'd1;
        do_finish            = (lead_len == 3'd1);
      end
    end

    // A sequence that decodes to zero is an overlong NUL and ends the text.
    if (do_finish) begin
      if (fin_pv == '0) begin
        do_stop     = 1'b1;
        stop_status = ST_END;
      end else begin
        res_valid       = 1'b1;
        res.code_point  = fin_pv;
        res.seq_length  = fin_len;
        char_count_next = char_count + COUNT_BITS'(1);
        byte_count_next = byte_count + COUNT_BITS'(fin_len);
      end
    end

    if (do_stop) begin
      res_valid            = 1'b1;
      res.status           = stop_status;
      halted_next          = 1'b1;
      bytes_remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
      sequence_length <= '0;
      char_count      <= '0;
      byte_count      <= '0;
      halted          <= 1'b0;
    end else begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      char_count      <= char_count_next;
      byte_count      <= byte_count_next;
      halted          <= halted_next;
    end
  end

endmodule

### sv/utf8d_out_reg.sv
module utf8d_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  utf8d_pkg::result_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               slot_free,
  output utf8d_pkg::result_t res_q
);
  import utf8d_pkg::*;

  logic out_valid_next;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

### sv/utf8_stream_decoder.sv
// Byte-serial decoder for the original UTF-8 scheme (sequences of up to six bytes, code
// points of up to 31 bits). It takes one byte per cycle and gives one beat per finished
// character, plus one status beat for end of text (a NUL lead or a sequence decoding to
// zero) or for an invalid sequence, after which every byte is taken and dropped until
// reset. A taken byte is held in the input register while the decode logic works on it,
// and the result is loaded into the output register once that register has room. The
// sustained rate is one byte per cycle while out_ready is high; a stalled result beat
// holds back the input only once the input register is also full.
// Overlong forms are accepted and the character and byte counters wrap.
module utf8_stream_decoder #(
  parameter int COUNT_BITS = utf8d_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic [2:0]  seq_length,
  output logic [1:0]  status,
  output logic [31:0] char_ordinal,
  output logic [31:0] byte_offset
);
  import utf8d_pkg::*;

  logic       s1_valid, s1_valid_next;
  logic [7:0] s1_byte;
  logic       slot_free;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  assign step     = s1_valid && slot_free;
  assign in_ready = !s1_valid || slot_free;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_valid && in_ready) begin
      s1_valid_next = 1'b1;
    end else if (step) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= text_byte;
    end
  end

  utf8d_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .res_q     (res_q)
  );

  assign code_point   = res_q.code_point;
  assign seq_length   = res_q.seq_length;
  assign status       = res_q.status;
  assign char_ordinal = res_q.char_ordinal;
  assign byte_offset  = res_q.byte_offset;

endmodule

### sv/utf8d_checker.sv
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  text_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] code_point,
  input logic [2:0]  seq_length,
  input logic [1:0]  status,
  input logic [31:0] char_ordinal,
  input logic [31:0] byte_offset
);
  import utf8d_pkg::*;

  logic stopped;

  // Set once an end or invalid beat has left the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (out_valid && out_ready && status != ST_CHAR) begin
      stopped <= 1'b1;
    end
  end

  a_silent_after_stop: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !out_valid)
    else $error("result beat after end or invalid status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_CHAR || status == ST_END || status == ST_INVALID))
    else $error("undefined status code");

  a_stop_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_CHAR) |-> (code_point == '0 && seq_length == '0))
    else $error("status beat carries a character");

  a_char_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_CHAR) |->
      (code_point != '0 && seq_length != 3'd0 && seq_length != 3'd7))
    else $error("character beat with bad value or length");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(code_point) && $stable(status) && $stable(byte_offset)))
    else $error("stalled result beat changed");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (.*);
